// ===== hw/rtl/mbe_pkg.sv =====
// mbe_pkg: shared types, constants and fixed-point helpers for the
// Mandelbrot escape-time block. No dependencies.
package mbe_pkg;

  localparam int FRAC_BITS_DEF  = 28;
  localparam int PIXEL_BITS_DEF = 10;
  localparam int QUEUE_DEPTH    = 2;

  localparam int WORD_W   = 32;
  localparam int STEP_W   = 31;
  localparam int ITER_W   = 16;
  localparam int PROD_W   = 64;
  localparam int SUM_W    = 66;
  localparam int ADDR_W   = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_START_RE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_IM = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_RE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_IM  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

  localparam logic [WORD_W-1:0] START_RE_RST = 32'hD800_0000;
  localparam logic [WORD_W-1:0] START_IM_RST = 32'hE800_0000;
  localparam logic [STEP_W-1:0] STEP_RE_RST  = 31'd2064888;
  localparam logic [STEP_W-1:0] STEP_IM_RST  = 31'd1830242;
  localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd1000;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // clamp a wide two's complement value to the signed 32-bit range
  function automatic logic [WORD_W-1:0] sat_word(input logic [SUM_W-1:0] v);
    logic fits;
    logic [WORD_W-1:0] res;
    fits = (v[SUM_W-1:WORD_W-1] == {(SUM_W-WORD_W+1){v[WORD_W-1]}});
    if (fits) begin
      res = v[WORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic [SUM_W-1:0] sext_word(input logic [WORD_W-1:0] v);
    return {{(SUM_W-WORD_W){v[WORD_W-1]}}, v};
  endfunction

endpackage

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// mandelbrot_escape_time: top level with APB register file, front, queue, back.
// Depends on mbe_pkg, mbe_front, mbe_queue, mbe_back.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------
//  request   | start / busy          | column, row
//  result    | done (1-cycle strobe) | out_column, out_row, iterations, inside_res
//  config    | APB psel/penable      | paddr, pwdata, prdata
//
// The front maps a request to c combinationally and pushes it into the queue; the
// back loads it, then runs one step of the shared z^2 + c datapath per iteration
// until the escape test or the limit stops it, and registers the result.
// The queue holds two mapped requests; busy is high while it is full.
// Reset loads the default view and empties the queue; results cannot stall.
module mandelbrot_escape_time #(
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
  parameter int PIXEL_BITS = mbe_pkg::PIXEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [PIXEL_BITS-1:0]        column,
  input  logic [PIXEL_BITS-1:0]        row,
  output logic                         done,
  output logic [PIXEL_BITS-1:0]        out_column,
  output logic [PIXEL_BITS-1:0]        out_row,
  output logic [mbe_pkg::ITER_W-1:0]   iterations,
  output logic                         inside_res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbe_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  localparam int DATA_W = 2 * PIXEL_BITS + 2 * mbe_pkg::WORD_W;

  logic [mbe_pkg::WORD_W-1:0]   start_re;
  logic [mbe_pkg::WORD_W-1:0]   start_im;
  logic [mbe_pkg::STEP_W-1:0]   step_re;
  logic [mbe_pkg::STEP_W-1:0]   step_im;
  logic [mbe_pkg::ITER_W-1:0]   max_iter;

  logic [mbe_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  mbe_pkg::q_status_t q_stat;
  logic               q_push;
  logic               q_pop;
  logic [DATA_W-1:0]  q_wdata;
  logic [DATA_W-1:0]  q_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mbe_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_re <= mbe_pkg::START_RE_RST;
      start_im <= mbe_pkg::START_IM_RST;
      step_re  <= mbe_pkg::STEP_RE_RST;
      step_im  <= mbe_pkg::STEP_IM_RST;
      max_iter <= mbe_pkg::MAX_ITER_RST;
    end else if (wr_en) begin
      case (reg_idx)
        mbe_pkg::REG_START_RE: start_re <= pwdata;
        mbe_pkg::REG_START_IM: start_im <= pwdata;
        mbe_pkg::REG_STEP_RE:  step_re  <= pwdata[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_STEP_IM:  step_im  <= pwdata[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_MAX_ITER: max_iter <= pwdata[mbe_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mbe_pkg::REG_START_RE: prdata = start_re;
      mbe_pkg::REG_START_IM: prdata = start_im;
      mbe_pkg::REG_STEP_RE:  prdata = 32'(step_re);
      mbe_pkg::REG_STEP_IM:  prdata = 32'(step_im);
      mbe_pkg::REG_MAX_ITER: prdata = 32'(max_iter);
      default:               prdata = '0;
    endcase
  end

  mbe_front #(
    .PIXEL_BITS (PIXEL_BITS),
    .DATA_W     (DATA_W)
  ) u_front (
    .start     (start),
    .busy      (busy),
    .column    (column),
    .row       (row),
    .start_re  (start_re),
    .start_im  (start_im),
    .step_re   (step_re),
    .step_im   (step_im),
    .q_status  (q_stat),
    .push      (q_push),
    .push_data (q_wdata)
  );

  mbe_queue #(
    .WIDTH (DATA_W),
    .DEPTH (mbe_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .status  (q_stat)
  );

  mbe_back #(
    .FRAC_BITS  (FRAC_BITS),
    .PIXEL_BITS (PIXEL_BITS),
    .DATA_W     (DATA_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .max_iter   (max_iter),
    .q_status   (q_stat),
    .pop_data   (q_rdata),
    .pop        (q_pop),
    .done       (done),
    .out_column (out_column),
    .out_row    (out_row),
    .iterations (iterations),
    .inside_res (inside_res)
  );

  // back returns through its idle (load) state between results, so strobes are never back to back
  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobes on consecutive cycles");

  // queue only fills through an accepted request
  a_full_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("queue filled without a request");

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

endmodule

// ===== hw/rtl/mbe_queue.sv =====
// mbe_queue: small flip-flop FIFO carrying requests from front to back.
// Depends on mbe_pkg (status struct).
module mbe_queue #(
  parameter int WIDTH = 84,
  parameter int DEPTH = mbe_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    wr_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    rd_data,
  output mbe_pkg::q_status_t  status
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign rd_data      = mem[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

endmodule

// ===== hw/rtl/mbe_front.sv =====
// mbe_front: accepts pixel requests and maps them to the complex point c.
// Depends on mbe_pkg (widths, saturation helpers).
module mbe_front #(
  parameter int PIXEL_BITS = mbe_pkg::PIXEL_BITS_DEF,
  parameter int DATA_W     = 2 * PIXEL_BITS + 2 * mbe_pkg::WORD_W
) (
  input  logic                              start,
  output logic                              busy,
  input  logic [PIXEL_BITS-1:0]             column,
  input  logic [PIXEL_BITS-1:0]             row,
  input  logic [mbe_pkg::WORD_W-1:0]        start_re,
  input  logic [mbe_pkg::WORD_W-1:0]        start_im,
  input  logic [mbe_pkg::STEP_W-1:0]        step_re,
  input  logic [mbe_pkg::STEP_W-1:0]        step_im,
  input  mbe_pkg::q_status_t                q_status,
  output logic                              push,
  output logic [DATA_W-1:0]                 push_data
);
  localparam int MUL_W = PIXEL_BITS + mbe_pkg::STEP_W;

  logic [MUL_W-1:0]             off_re;
  logic [MUL_W-1:0]             off_im;
  logic [mbe_pkg::SUM_W-1:0]    sum_re;
  logic [mbe_pkg::SUM_W-1:0]    sum_im;
  logic [mbe_pkg::WORD_W-1:0]   c_re;
  logic [mbe_pkg::WORD_W-1:0]   c_im;

  assign off_re = MUL_W'(column) * MUL_W'(step_re);
  assign off_im = MUL_W'(row) * MUL_W'(step_im);
  assign sum_re = mbe_pkg::SUM_W'(off_re) + mbe_pkg::sext_word(start_re);
  assign sum_im = mbe_pkg::SUM_W'(off_im) + mbe_pkg::sext_word(start_im);
  assign c_re   = mbe_pkg::sat_word(sum_re);
  assign c_im   = mbe_pkg::sat_word(sum_im);

  assign busy      = q_status.full;
  assign push      = start && !q_status.full;
  assign push_data = {column, row, c_re, c_im};

endmodule

// ===== hw/rtl/mbe_back.sv =====
// mbe_back: escape-time iteration z = z^2 + c, one step per cycle, with
// registered result. Depends on mbe_pkg (state type, saturation helpers).
module mbe_back #(
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
  parameter int PIXEL_BITS = mbe_pkg::PIXEL_BITS_DEF,
  parameter int DATA_W     = 2 * PIXEL_BITS + 2 * mbe_pkg::WORD_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [mbe_pkg::ITER_W-1:0]   max_iter,
  input  mbe_pkg::q_status_t           q_status,
  input  logic [DATA_W-1:0]            pop_data,
  output logic                         pop,
  output logic                         done,
  output logic [PIXEL_BITS-1:0]        out_column,
  output logic [PIXEL_BITS-1:0]        out_row,
  output logic [mbe_pkg::ITER_W-1:0]   iterations,
  output logic                         inside_res
);
  localparam int W  = mbe_pkg::WORD_W;
  localparam int PW = mbe_pkg::PROD_W;
  localparam int SW = mbe_pkg::SUM_W;

  mbe_pkg::state_t state, state_next;

  logic [PIXEL_BITS-1:0]      col;
  logic [PIXEL_BITS-1:0]      rw;
  logic signed [W-1:0]        x;
  logic signed [W-1:0]        y;
  logic [W-1:0]               cre;
  logic [W-1:0]               cim;
  logic [mbe_pkg::ITER_W-1:0] count;

  logic signed [PW-1:0] p_xx;
  logic signed [PW-1:0] p_yy;
  logic signed [PW-1:0] p_xy;
  logic [PW-1:0]        xx;
  logic [PW-1:0]        yy;
  logic signed [PW-1:0] xy_sh;
  logic [PW:0]          mag;
  logic [SW-1:0]        nx_sum;
  logic [SW-1:0]        ny_sum;
  logic                 limit_hit;
  logic                 escape;
  logic                 load;
  logic                 finish;
  logic                 advance;

  assign p_xx  = x * x;
  assign p_yy  = y * y;
  assign p_xy  = x * y;
  assign xx    = $unsigned(p_xx) >> FRAC_BITS;
  assign yy    = $unsigned(p_yy) >> FRAC_BITS;
  assign xy_sh = p_xy >>> (FRAC_BITS - 1);
  assign mag   = {1'b0, xx} + {1'b0, yy};

  assign limit_hit = (count >= max_iter);
  assign escape    = (mag > ((PW + 1)'(4) << FRAC_BITS)) || limit_hit;

  assign nx_sum = {2'b00, xx} - {2'b00, yy} + mbe_pkg::sext_word(cre);
  assign ny_sum = {{(SW-PW){xy_sh[PW-1]}}, xy_sh} + mbe_pkg::sext_word(cim);

  always_comb begin
    state_next = state;
    case (state)
      mbe_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          state_next = mbe_pkg::ST_RUN;
        end
      end
      mbe_pkg::ST_RUN: begin
        if (escape) begin
          state_next = mbe_pkg::ST_IDLE;
        end
      end
      default: state_next = mbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    load    = 1'b0;
    finish  = 1'b0;
    advance = 1'b0;
    case (state)
      mbe_pkg::ST_IDLE: load = !q_status.empty;
      mbe_pkg::ST_RUN: begin
        finish  = escape;
        advance = !escape;
      end
      default: ;
    endcase
  end

  assign pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbe_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      col   <= pop_data[DATA_W-1 -: PIXEL_BITS];
      rw    <= pop_data[2*W +: PIXEL_BITS];
      cre   <= pop_data[W +: W];
      cim   <= pop_data[0 +: W];
      x     <= $signed(pop_data[W +: W]);
      y     <= $signed(pop_data[0 +: W]);
      count <= '0;
    end else if (advance) begin
      x     <= $signed(mbe_pkg::sat_word(nx_sum));
      y     <= $signed(mbe_pkg::sat_word(ny_sum));
      count <= count + mbe_pkg::ITER_W'(1);
    end
    if (finish) begin
      out_column <= col;
      out_row    <= rw;
      iterations <= count;
      inside_res <= limit_hit;
    end
  end

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for mandelbrot_escape_time; predicts each pixel's
// escape count in Q4.28 and compares every result strobe against it.
// Depends on mbe_pkg and the mandelbrot_escape_time RTL.
module testbench;

  localparam int     FRAC        = mbe_pkg::FRAC_BITS_DEF;
  localparam int     PIXEL_W     = mbe_pkg::PIXEL_BITS_DEF;
  localparam int     FX_ONE      = 1 << FRAC;
  localparam longint ESCAPE_SQ   = longint'(4) << FRAC;
  localparam int     CYCLE_LIMIT = 3_000_000;
  localparam int     RANDOM_REQS = 600;

  typedef struct packed {
    logic [PIXEL_W-1:0]         col;
    logic [PIXEL_W-1:0]         row;
    logic [mbe_pkg::ITER_W-1:0] iters;
    logic                       in_set;
  } pixel_result_t;

  class escape_scoreboard;
    logic signed [31:0]          start_re;
    logic signed [31:0]          start_im;
    logic [mbe_pkg::STEP_W-1:0]  step_re;
    logic [mbe_pkg::STEP_W-1:0]  step_im;
    logic [mbe_pkg::ITER_W-1:0]  max_iter;
    pixel_result_t               pending_q[$];
    int                          mismatches;
    int                          checked;
    int                          in_set_seen;
    int                          deepest;

    function new();
      start_re    = -671088640;
      start_im    = -402653184;
      step_re     = 2064888;
      step_im     = 1830242;
      max_iter    = 1000;
      mismatches  = 0;
      checked     = 0;
      in_set_seen = 0;
      deepest     = 0;
    endfunction

    function void write_reg(logic [mbe_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        mbe_pkg::REG_START_RE: start_re = value;
        mbe_pkg::REG_START_IM: start_im = value;
        mbe_pkg::REG_STEP_RE:  step_re  = value[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_STEP_IM:  step_im  = value[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_MAX_ITER: max_iter = value[mbe_pkg::ITER_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_request(logic [PIXEL_W-1:0] col, logic [PIXEL_W-1:0] row);
      longint        c_re, c_im, x, y, xx, yy, nx;
      int            count;
      bit            halted;
      pixel_result_t r;
      c_re   = clamp_word(longint'(start_re) + longint'(col) * longint'(step_re));
      c_im   = clamp_word(longint'(start_im) + longint'(row) * longint'(step_im));
      x      = c_re;
      y      = c_im;
      count  = 0;
      halted = 0;
      while (!halted) begin
        xx = (x * x) >>> FRAC;
        yy = (y * y) >>> FRAC;
        if (xx + yy > ESCAPE_SQ || count >= max_iter) begin
          halted = 1;
        end else begin
          nx    = clamp_word(xx - yy + c_re);
          y     = clamp_word(((x * y) >>> (FRAC - 1)) + c_im);
          x     = nx;
          count++;
        end
      end
      r.col    = col;
      r.row    = row;
      r.iters  = count[mbe_pkg::ITER_W-1:0];
      r.in_set = (count >= max_iter);
      pending_q.push_back(r);
    endfunction

    function void flag(string why, pixel_result_t want, pixel_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $write("%s: expected col %0d row %0d iters %0d in_set %0b, ",
               why, want.col, want.row, want.iters, want.in_set);
        $display("got col %0d row %0d iters %0d in_set %0b",
                 got.col, got.row, got.iters, got.in_set);
      end
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (pending_q.size() == 0) begin
        flag("result with no request pending", '0, got);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (want.in_set) in_set_seen++;
      if (int'(want.iters) > deepest) deepest = int'(want.iters);
      if (got.col !== want.col || got.row !== want.row ||
          got.iters !== want.iters || got.in_set !== want.in_set)
        flag("pixel result differs", want, got);
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst     = 1'b1;
  logic                          start   = 1'b0;
  logic                          busy;
  logic [PIXEL_W-1:0]            column  = '0;
  logic [PIXEL_W-1:0]            row     = '0;
  logic                          done;
  logic [PIXEL_W-1:0]            out_column;
  logic [PIXEL_W-1:0]            out_row;
  logic [mbe_pkg::ITER_W-1:0]    iterations;
  logic                          inside_res;
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [mbe_pkg::ADDR_W-1:0]    paddr   = '0;
  logic [31:0]                   pwdata  = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  escape_scoreboard sb;
  int               cycle_count = 0;
  int               views = 0;

  mandelbrot_escape_time u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .column     (column),
    .row        (row),
    .done       (done),
    .out_column (out_column),
    .out_row    (out_row),
    .iterations (iterations),
    .inside_res (inside_res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result({out_column, out_row, iterations, inside_res});
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_pixel(input logic [PIXEL_W-1:0] c, input logic [PIXEL_W-1:0] r,
                            input int gap);
    start  <= 1'b1;
    column <= c;
    row    <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(c, r);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off new requests until every pending pixel has reported
  task automatic drain();
    if (start) start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic program_view(input logic [31:0] sre, input logic [31:0] sim,
                              input logic [31:0] stre, input logic [31:0] stim,
                              input logic [31:0] iter_limit);
    logic [31:0]                   vals [5];
    logic [mbe_pkg::REG_IDX_W-1:0] idx;
    vals[mbe_pkg::REG_START_RE] = sre;
    vals[mbe_pkg::REG_START_IM] = sim;
    vals[mbe_pkg::REG_STEP_RE]  = stre;
    vals[mbe_pkg::REG_STEP_IM]  = stim;
    vals[mbe_pkg::REG_MAX_ITER] = iter_limit;
    for (idx = mbe_pkg::REG_START_RE; idx <= mbe_pkg::REG_MAX_ITER; idx++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= vals[idx];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      sb.write_reg(idx, vals[idx]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    views++;
  endtask

  initial begin
    int random_sent;
    int n;
    int pick;
    bit quiet;
    logic [31:0] sre, sim, stre, stim, lim;

    sb = new();
    random_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default view: corners, alternating bits, points on the real axis inside the set
    send_pixel(10'd0,    10'd0,    pick_gap());
    send_pixel(10'd1023, 10'd1023, pick_gap());
    send_pixel(10'd0,    10'd1023, pick_gap());
    send_pixel(10'd1023, 10'd0,    pick_gap());
    send_pixel(10'd260,  10'd220,  pick_gap());
    send_pixel(10'd130,  10'd220,  pick_gap());
    send_pixel(10'd555,  10'd555,  pick_gap());
    send_pixel(10'h2AA,  10'h155,  pick_gap());
    send_pixel(10'h155,  10'h2AA,  pick_gap());
    drain();

    // extreme registers: c saturates, limit of one
    program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
    send_pixel(10'd0,    10'd0,    0);
    send_pixel(10'd1023, 10'd1023, 0);
    send_pixel(10'd1,    10'd0,    0);
    send_pixel(10'd0,    10'd1,    pick_gap());
    drain();

    // unit grid on the axes: |z|^2 landing exactly on 4, c = -2, -1, 0, 1, 2, i
    program_view(-2 * FX_ONE, 32'd0, FX_ONE, FX_ONE, 32'd64);
    send_pixel(10'd0, 10'd0, pick_gap());
    send_pixel(10'd1, 10'd0, pick_gap());
    send_pixel(10'd2, 10'd0, pick_gap());
    send_pixel(10'd3, 10'd0, pick_gap());
    send_pixel(10'd4, 10'd0, pick_gap());
    send_pixel(10'd2, 10'd1, pick_gap());
    drain();

    // zero limit: no iteration, always flagged in the set
    program_view(32'd0, 32'd0, FX_ONE, FX_ONE, 32'd0);
    send_pixel(10'd0,    10'd0,    0);
    send_pixel(10'd1023, 10'd1023, 0);
    send_pixel(10'd5,    10'd7,    pick_gap());
    drain();

    // largest limit: two points that never escape and one that leaves at once
    program_view(32'd0, 32'd0, FX_ONE, FX_ONE, 32'd65535);
    send_pixel(10'd0, 10'd0, 0);
    send_pixel(10'd3, 10'd0, 0);
    send_pixel(10'd0, 10'd1, pick_gap());
    drain();

    while (random_sent < RANDOM_REQS) begin
      drain();
      if ($urandom_range(0, 2) != 0) begin
        // window around the set, so points iterate
        sre  = int'($urandom_range(0, 2 * FX_ONE)) - (5 * FX_ONE) / 2;
        sim  = int'($urandom_range(0, 3 * FX_ONE / 2)) - 3 * FX_ONE / 2;
        stre = $urandom_range(2000, 800000);
        stim = $urandom_range(2000, 800000);
        pick = $urandom_range(0, 9);
        if (pick < 7)      lim = $urandom_range(1, 64);
        else if (pick < 9) lim = $urandom_range(65, 400);
        else               lim = 1000;
      end else begin
        sre  = $urandom;
        sim  = $urandom;
        stre = ($urandom_range(0, 1) != 0) ? ($urandom >> 1) : $urandom_range(0, 1 << 20);
        stim = ($urandom_range(0, 1) != 0) ? ($urandom >> 1) : $urandom_range(0, 1 << 20);
        lim  = $urandom_range(1, 512);
      end
      program_view(sre, sim, stre, stim, lim);
      n     = $urandom_range(30, 70);
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
        send_pixel(PIXEL_W'($urandom_range(0, 1023)), PIXEL_W'($urandom_range(0, 1023)),
                   quiet ? 0 : pick_gap());
        if ($urandom_range(0, 24) == 0) drain();
        random_sent++;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d pixels checked over %0d programmed views plus the reset view",
             sb.checked, views);
    $display("%0d pixels hit the limit, deepest run %0d iterations, %0d mismatches",
             sb.in_set_seen, sb.deepest, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_queue.sv
hw/rtl/mbe_front.sv
hw/rtl/mbe_back.sv
hw/rtl/mandelbrot_escape_time.sv
dv/testbench.sv
